>>> rtl/core/spcp_pkg.sv
package spcp_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SAT_W     = 31;
  localparam int PROD_W    = 2 * SAT_W;
  localparam int DOT_W     = PROD_W + 1;
  localparam int OPD_W     = 64;
  localparam int WIDE_W    = 2 * OPD_W;
  localparam int FRAC_W    = 16;
  localparam int PARAM_W   = FRAC_W + 1;
  localparam int DIV_STEPS = FRAC_W;
  localparam int MUL_LAT   = 3;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int TOL_W     = 32;

  localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(4295);
  localparam logic [PARAM_W-1:0] ONE_Q16   = PARAM_W'(1) << FRAC_W;
  localparam logic [SAT_W-1:0]   SAT_HI    = {1'b0, {(SAT_W-1){1'b1}}};
  localparam logic [SAT_W-1:0]   SAT_LO    = {1'b1, {(SAT_W-1){1'b0}}};

  // Clamp a difference to [-2^30, 2^30-1].
  function automatic logic signed [SAT_W-1:0] sat_diff(input logic signed [DIFF_W-1:0] x);
    logic [DIFF_W-SAT_W:0] top;
    top = x[DIFF_W-1:SAT_W-1];
    if (top == '0 || top == '1) begin
      return x[SAT_W-1:0];
    end else if (x[DIFF_W-1]) begin
      return SAT_LO;
    end else begin
      return SAT_HI;
    end
  endfunction

endpackage

>>> rtl/core/spcp_delay.sv
module spcp_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign dout = line_r[D-1];

endmodule

>>> rtl/core/spcp_mul.sv
module spcp_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [spcp_pkg::OPD_W-1:0]    op_a,
  input  logic signed [spcp_pkg::OPD_W-1:0]    op_b,
  output logic signed [spcp_pkg::WIDE_W-1:0]   prod
);
  import spcp_pkg::*;

  localparam int HALF_W = OPD_W / 2;

  logic [OPD_W-1:0]  ua_r, ub_r;
  logic              neg0_r, neg1_r;
  logic [OPD_W-1:0]  p00_r, p01_r, p10_r, p11_r;
  logic [WIDE_W-1:0] sum;

  // Sign-magnitude: split magnitudes into 32-bit halves, four partials.
  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= op_a[OPD_W-1] ? OPD_W'(-op_a) : OPD_W'(op_a);
      ub_r   <= op_b[OPD_W-1] ? OPD_W'(-op_b) : OPD_W'(op_b);
      neg0_r <= op_a[OPD_W-1] ^ op_b[OPD_W-1];
      p00_r  <= ua_r[HALF_W-1:0] * ub_r[HALF_W-1:0];
      p01_r  <= ua_r[HALF_W-1:0] * ub_r[OPD_W-1:HALF_W];
      p10_r  <= ua_r[OPD_W-1:HALF_W] * ub_r[HALF_W-1:0];
      p11_r  <= ua_r[OPD_W-1:HALF_W] * ub_r[OPD_W-1:HALF_W];
      neg1_r <= neg0_r;
      prod   <= neg1_r ? -sum : sum;
    end
  end

  assign sum = {{OPD_W{1'b0}}, p00_r}
             + {{HALF_W{1'b0}}, p01_r, {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, p10_r, {HALF_W{1'b0}}}
             + {p11_r, {OPD_W{1'b0}}};

endmodule

>>> rtl/core/spcp_div.sv
module spcp_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic [spcp_pkg::WIDE_W-1:0]         num,
  input  logic [spcp_pkg::WIDE_W-1:0]         den,
  output logic [spcp_pkg::PARAM_W-1:0]        quo
);
  import spcp_pkg::*;

  logic [WIDE_W-1:0]    rem_r  [DIV_STEPS+1];
  logic [WIDE_W-1:0]    den_r  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_r    [DIV_STEPS+1];
  logic                 zero_r [DIV_STEPS+1];
  logic                 one_r  [DIV_STEPS+1];

  // Entry: flag non-positive numerators and ratios at or above one.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      zero_r[0] <= num[WIDE_W-1] || (num == '0);
      one_r[0]  <= (num >= den);
    end
  end

  for (genvar gi = 1; gi <= DIV_STEPS; gi++) begin : g_step
    logic [WIDE_W-1:0] sh;
    logic              ge;

    always_comb begin
      sh = {rem_r[gi-1][WIDE_W-2:0], 1'b0};
      ge = (sh >= den_r[gi-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi]  <= ge ? sh - den_r[gi-1] : sh;
        den_r[gi]  <= den_r[gi-1];
        q_r[gi]    <= {q_r[gi-1][DIV_STEPS-2:0], ge};
        zero_r[gi] <= zero_r[gi-1];
        one_r[gi]  <= one_r[gi-1];
      end
    end
  end

  assign quo = zero_r[DIV_STEPS] ? '0 :
               one_r[DIV_STEPS]  ? ONE_Q16 : {1'b0, q_r[DIV_STEPS]};

endmodule

>>> rtl/core/segment_pair_closest_points.sv
// Throughput: one item per cycle; a stalled output freezes every stage.
// The depth is set by three chained 17-stage dividers (initial parameters,
// then the refinement of B and of A), plus the 64x64 multipliers between them.
// Reset (synchronous, rst_n low) clears all stage valids and loads the
// tolerance register with 4295.
module segment_pair_closest_points (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,      // zero_tolerance
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
  // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z (32 bits each)
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z (32 bits each)
  output logic [191:0] out_tdata
);
  import spcp_pkg::*;

  localparam int N_IN     = 12;
  localparam int N_AX     = 3;
  localparam int ST_COEF  = 3;
  localparam int ST_SUM   = ST_COEF + MUL_LAT + 1;
  localparam int ST_SEL   = ST_SUM + 1;
  localparam int ST_P0    = ST_SEL + DIV_LAT;
  localparam int ST_M1    = ST_P0 + MUL_LAT;
  localparam int ST_N1    = ST_M1 + 1;
  localparam int ST_P1    = ST_N1 + DIV_LAT;
  localparam int ST_M2    = ST_P1 + MUL_LAT;
  localparam int ST_N2    = ST_M2 + 1;
  localparam int ST_P2    = ST_N2 + DIV_LAT;
  localparam int NSTG     = ST_P2 + 2;

  typedef struct packed {
    logic signed [DOT_W-1:0] a;
    logic signed [DOT_W-1:0] e;
    logic signed [DOT_W-1:0] b;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] f;
    logic                    pt_a;
    logic                    pt_e;
  } coef_t;

  typedef struct packed {
    logic [N_AX-1:0][COORD_W-1:0] as;
    logic [N_AX-1:0][COORD_W-1:0] bs;
    logic [N_AX-1:0][DIFF_W-1:0]  d1;
    logic [N_AX-1:0][DIFF_W-1:0]  d2;
  } geom_t;

  logic                      en;
  logic [NSTG-1:0]           vld_r;
  logic [TOL_W-1:0]          tol_r;

  logic signed [COORD_W-1:0] s [N_IN];
  geom_t                     geom_nxt, geom_r, geom_late;
  logic signed [SAT_W-1:0]   q1_r [N_AX], q2_r [N_AX], qr_r [N_AX];
  logic signed [PROD_W-1:0]  pa_r [N_AX], pe_r [N_AX], pb_r [N_AX], pc_r [N_AX], pf_r [N_AX];
  logic signed [DOT_W-1:0]   a_r, e_r, b_r, c_r, f_r;
  coef_t                     coef3, coef7, coef8_r, coef25, coef28, coef46, coef49;

  logic signed [WIDE_W-1:0]  m_ae, m_bb, m_bf, m_ce, m_af, m_bc, m1, m2;
  logic signed [WIDE_W-1:0]  denom_r, na_r, nb_r;
  logic signed [WIDE_W-1:0]  nA_nxt, dA_nxt, nB_nxt, dB_nxt;
  logic signed [WIDE_W-1:0]  nA_r, dA_r, nB_r, dB_r;
  logic                      gen_r, refine_r, refine_late;
  logic [WIDE_W-1:0]         thr;

  logic [PARAM_W-1:0]        pA0, pB0, pB1, pA1, pA0_late, pB0_late, pB1_late, pa_fin, pb_fin;
  logic signed [WIDE_W-1:0]  num1_r, den1_r, num2_r, den2_r;

  logic signed [DIFF_W+PARAM_W:0] lp_r [2*N_AX];
  logic signed [COORD_W-1:0]      st_r [2*N_AX];
  logic [COORD_W-1:0]             near_r [2*N_AX];

  function automatic logic in_unit(input logic [WIDE_W-1:0] n, input logic [WIDE_W-1:0] d);
    return !n[WIDE_W-1] && (n <= d);
  endfunction

  assign en         = !vld_r[NSTG-1] || out_tready;
  assign in_tready  = en;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      tol_r <= TOL_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[NSTG-2:0], in_tvalid};
      end
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
    end
  end

  // Stage 1: differences, saturated copies for the dot products.
  always_comb begin
    for (int i = 0; i < N_IN; i++) begin
      s[i] = in_tdata[COORD_W*i +: COORD_W];
    end
    for (int i = 0; i < N_AX; i++) begin
      geom_nxt.as[i] = s[i];
      geom_nxt.bs[i] = s[6+i];
      geom_nxt.d1[i] = DIFF_W'(s[3+i]) - DIFF_W'(s[i]);
      geom_nxt.d2[i] = DIFF_W'(s[9+i]) - DIFF_W'(s[6+i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geom_r <= geom_nxt;
      for (int i = 0; i < N_AX; i++) begin
        q1_r[i] <= sat_diff(geom_nxt.d1[i]);
        q2_r[i] <= sat_diff(geom_nxt.d2[i]);
        qr_r[i] <= sat_diff(DIFF_W'(s[i]) - DIFF_W'(s[6+i]));
      end
    end
  end

  // Stage 2: fifteen products; stage 3: dot sums.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_AX; i++) begin
        pa_r[i] <= q1_r[i] * q1_r[i];
        pe_r[i] <= q2_r[i] * q2_r[i];
        pb_r[i] <= q1_r[i] * q2_r[i];
        pc_r[i] <= q1_r[i] * qr_r[i];
        pf_r[i] <= q2_r[i] * qr_r[i];
      end
      a_r <= DOT_W'(pa_r[0]) + DOT_W'(pa_r[1]) + DOT_W'(pa_r[2]);
      e_r <= DOT_W'(pe_r[0]) + DOT_W'(pe_r[1]) + DOT_W'(pe_r[2]);
      b_r <= DOT_W'(pb_r[0]) + DOT_W'(pb_r[1]) + DOT_W'(pb_r[2]);
      c_r <= DOT_W'(pc_r[0]) + DOT_W'(pc_r[1]) + DOT_W'(pc_r[2]);
      f_r <= DOT_W'(pf_r[0]) + DOT_W'(pf_r[1]) + DOT_W'(pf_r[2]);
    end
  end

  always_comb begin
    coef3.a    = a_r;
    coef3.e    = e_r;
    coef3.b    = b_r;
    coef3.c    = c_r;
    coef3.f    = f_r;
    coef3.pt_a = (a_r <= DOT_W'(signed'({1'b0, tol_r})));
    coef3.pt_e = (e_r <= DOT_W'(signed'({1'b0, tol_r})));
  end

  spcp_mul u_mul_ae (.clk, .en, .op_a(OPD_W'(a_r)), .op_b(OPD_W'(e_r)), .prod(m_ae));
  spcp_mul u_mul_bb (.clk, .en, .op_a(OPD_W'(b_r)), .op_b(OPD_W'(b_r)), .prod(m_bb));
  spcp_mul u_mul_bf (.clk, .en, .op_a(OPD_W'(b_r)), .op_b(OPD_W'(f_r)), .prod(m_bf));
  spcp_mul u_mul_ce (.clk, .en, .op_a(OPD_W'(c_r)), .op_b(OPD_W'(e_r)), .prod(m_ce));
  spcp_mul u_mul_af (.clk, .en, .op_a(OPD_W'(a_r)), .op_b(OPD_W'(f_r)), .prod(m_af));
  spcp_mul u_mul_bc (.clk, .en, .op_a(OPD_W'(b_r)), .op_b(OPD_W'(c_r)), .prod(m_bc));

  spcp_delay #(.W($bits(coef_t)), .D(ST_SUM - ST_COEF)) u_dly_coef7 (
    .clk, .en, .din(coef3), .dout(coef7)
  );

  // Pick numerators and divisors for the first pair of quotients.
  always_comb begin
    thr    = WIDE_W'({tol_r, {TOL_W{1'b0}}});
    nA_nxt = '0;
    dA_nxt = WIDE_W'(1);
    nB_nxt = '0;
    dB_nxt = WIDE_W'(1);
    if (coef7.pt_a && !coef7.pt_e) begin
      nB_nxt = WIDE_W'(coef7.f);
      dB_nxt = WIDE_W'(coef7.e);
    end else if (!coef7.pt_a && coef7.pt_e) begin
      nA_nxt = -WIDE_W'(coef7.c);
      dA_nxt = WIDE_W'(coef7.a);
    end else if (!coef7.pt_a && !coef7.pt_e) begin
      if (denom_r > signed'(thr)) begin
        nA_nxt = na_r;
        dA_nxt = denom_r;
        nB_nxt = nb_r;
        dB_nxt = denom_r;
      end else begin
        nB_nxt = WIDE_W'(coef7.f);
        dB_nxt = WIDE_W'(coef7.e);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      denom_r  <= m_ae - m_bb;
      na_r     <= m_bf - m_ce;
      nb_r     <= m_af - m_bc;
      nA_r     <= nA_nxt;
      dA_r     <= dA_nxt;
      nB_r     <= nB_nxt;
      dB_r     <= dB_nxt;
      gen_r    <= !coef7.pt_a && !coef7.pt_e;
      coef8_r  <= coef7;
      refine_r <= gen_r && !(in_unit(nA_r, dA_r) && in_unit(nB_r, dB_r));
    end
  end

  spcp_div u_div_a0 (.clk, .en, .num(nA_r), .den(dA_r), .quo(pA0));
  spcp_div u_div_b0 (.clk, .en, .num(nB_r), .den(dB_r), .quo(pB0));

  spcp_delay #(.W($bits(coef_t)), .D(ST_P0 - ST_SEL)) u_dly_coef25 (
    .clk, .en, .din(coef8_r), .dout(coef25)
  );

  // Refine B from the first A parameter.
  spcp_mul u_mul_r1 (
    .clk, .en, .op_a(OPD_W'(coef25.b)), .op_b(signed'(OPD_W'(pA0))), .prod(m1)
  );

  spcp_delay #(.W($bits(coef_t)), .D(MUL_LAT)) u_dly_coef28 (
    .clk, .en, .din(coef25), .dout(coef28)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= (WIDE_W'(coef28.f) <<< FRAC_W) + m1;
      den1_r <= WIDE_W'(coef28.e) <<< FRAC_W;
    end
  end

  spcp_div u_div_b1 (.clk, .en, .num(num1_r), .den(den1_r), .quo(pB1));

  spcp_delay #(.W($bits(coef_t)), .D(ST_P1 - ST_M1)) u_dly_coef46 (
    .clk, .en, .din(coef28), .dout(coef46)
  );

  // Refine A from the refined B parameter.
  spcp_mul u_mul_r2 (
    .clk, .en, .op_a(OPD_W'(coef46.b)), .op_b(signed'(OPD_W'(pB1))), .prod(m2)
  );

  spcp_delay #(.W($bits(coef_t)), .D(MUL_LAT)) u_dly_coef49 (
    .clk, .en, .din(coef46), .dout(coef49)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r <= (-WIDE_W'(coef49.c) <<< FRAC_W) + m2;
      den2_r <= WIDE_W'(coef49.a) <<< FRAC_W;
    end
  end

  spcp_div u_div_a1 (.clk, .en, .num(num2_r), .den(den2_r), .quo(pA1));

  // Align everything to the last divider's output.
  spcp_delay #(.W($bits(geom_t)), .D(ST_P2 - 1)) u_dly_geom (
    .clk, .en, .din(geom_r), .dout(geom_late)
  );
  spcp_delay #(.W(2*PARAM_W), .D(ST_P2 - ST_P0)) u_dly_p0 (
    .clk, .en, .din({pA0, pB0}), .dout({pA0_late, pB0_late})
  );
  spcp_delay #(.W(PARAM_W), .D(ST_P2 - ST_P1)) u_dly_p1 (
    .clk, .en, .din(pB1), .dout(pB1_late)
  );
  spcp_delay #(.W(1), .D(ST_P2 - ST_SEL - 1)) u_dly_refine (
    .clk, .en, .din(refine_r), .dout(refine_late)
  );

  assign pa_fin = refine_late ? pA1 : pA0_late;
  assign pb_fin = refine_late ? pB1_late : pB0_late;

  // Interpolate: start + floor(d * param / 2^16), wrapped to 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_AX; i++) begin
        lp_r[i]      <= signed'(geom_late.d1[i]) * signed'({1'b0, pa_fin});
        lp_r[N_AX+i] <= signed'(geom_late.d2[i]) * signed'({1'b0, pb_fin});
        st_r[i]      <= geom_late.as[i];
        st_r[N_AX+i] <= geom_late.bs[i];
      end
      for (int i = 0; i < 2*N_AX; i++) begin
        near_r[i] <= st_r[i] + lp_r[i][FRAC_W+COORD_W-1:FRAC_W];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2*N_AX; i++) begin
      out_tdata[COORD_W*i +: COORD_W] = near_r[i];
    end
  end

endmodule

>>> tb/spcp_checker.sv
module spcp_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [383:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE_Q16 = 65536;

  logic [31:0]  tolerance;
  logic [191:0] expected_points[$];
  string        field_names[6] = '{"near_a_x", "near_a_y", "near_a_z",
                                   "near_b_x", "near_b_y", "near_b_z"};

  function automatic longint clip30(input longint x);
    if (x > 64'sd1073741823) return 64'sd1073741823;
    if (x < -64'sd1073741824) return -64'sd1073741824;
    return x;
  endfunction

  function automatic logic signed [127:0] wide(input longint x);
    logic signed [127:0] r;
    r = x;
    return r;
  endfunction

  // clamp num/den to [0,1], truncate to Q1.16
  function automatic longint param_q16(input logic signed [127:0] num,
                                       input logic signed [127:0] den);
    logic signed [159:0] n;
    logic signed [159:0] dd;
    if (num <= 0) return 0;
    if (num >= den) return ONE_Q16;
    n = num;
    dd = den;
    n = n <<< 16;
    return longint'(n / dd);
  endfunction

  function automatic bit in_unit(input logic signed [127:0] num,
                                 input logic signed [127:0] den);
    return num >= 0 && num <= den;
  endfunction

  function automatic logic [31:0] lerp_point(input longint start, input longint d,
                                             input longint p);
    longint pr;
    pr = d * p;
    return 32'(start + (pr >>> 16));
  endfunction

  function automatic logic [191:0] closest_pair(input logic [383:0] seg,
                                                input logic [31:0] tol);
    longint s[12];
    longint d1[3], d2[3], q1[3], q2[3], qr[3];
    longint a, b, c, e, f, pa, pb, tl;
    logic signed [127:0] den, thr, na, da, nb, db;
    logic [191:0] res;
    for (int i = 0; i < 12; i++) s[i] = longint'($signed(seg[32*i +: 32]));
    for (int i = 0; i < 3; i++) begin
      d1[i] = s[3+i] - s[i];
      d2[i] = s[9+i] - s[6+i];
      q1[i] = clip30(d1[i]);
      q2[i] = clip30(d2[i]);
      qr[i] = clip30(s[i] - s[6+i]);
    end
    a = 0; b = 0; c = 0; e = 0; f = 0;
    for (int i = 0; i < 3; i++) begin
      a += q1[i] * q1[i];
      e += q2[i] * q2[i];
      b += q1[i] * q2[i];
      c += q1[i] * qr[i];
      f += q2[i] * qr[i];
    end
    tl = longint'(tol);
    if (a <= tl && e <= tl) begin
      pa = 0;
      pb = 0;
    end else if (a <= tl) begin
      pa = 0;
      pb = param_q16(wide(f), wide(e));
    end else if (e <= tl) begin
      pa = param_q16(wide(-c), wide(a));
      pb = 0;
    end else begin
      den = wide(a) * wide(e) - wide(b) * wide(b);
      thr = {64'b0, tol, 32'b0};
      if (den > thr) begin
        na = wide(b) * wide(f) - wide(c) * wide(e);
        nb = wide(a) * wide(f) - wide(b) * wide(c);
        da = den;
        db = den;
      end else begin
        na = 0;
        da = 1;
        nb = wide(f);
        db = wide(e);
      end
      pa = param_q16(na, da);
      if (in_unit(na, da) && in_unit(nb, db)) begin
        pb = param_q16(nb, db);
      end else begin
        // refine B from A, then A from B
        pb = param_q16(wide(f) * ONE_Q16 + wide(b) * wide(pa), wide(e) * ONE_Q16);
        pa = param_q16(wide(-c) * ONE_Q16 + wide(b) * wide(pb), wide(a) * ONE_Q16);
      end
    end
    for (int i = 0; i < 3; i++) begin
      res[32*i +: 32]     = lerp_point(s[i], d1[i], pa);
      res[32*(3+i) +: 32] = lerp_point(s[6+i], d2[i], pb);
    end
    return res;
  endfunction

  assign pending = expected_points.size();

  always @(posedge clk) begin
    logic [191:0] exp_pt;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      tolerance <= 32'd4295;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
      if (in_tvalid && in_tready) expected_points.push_back(closest_pair(in_tdata, tolerance));
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("result item with nothing expected: %h", out_tdata);
          errs++;
        end else begin
          exp_pt = expected_points.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (exp_pt[32*i +: 32] !== out_tdata[32*i +: 32]) begin
              $error("%s: expected %0d, got %0d", field_names[i],
                     $signed(exp_pt[32*i +: 32]), $signed(out_tdata[32*i +: 32]));
              errs++;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> tb/tb_segment_pair_closest_points.sv
module tb_segment_pair_closest_points;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  int           fail_count;
  int           pending;

  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_seen;
  int hold_cnt;

  segment_pair_closest_points u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  spcp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("tb_segment_pair_closest_points NOT OK");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    hold_seen = 0;
    hold_cnt = 0;
  end
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 300;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [383:0] seg_item(input int v[12]);
    logic [383:0] r;
    for (int i = 0; i < 12; i++) r[32*i +: 32] = v[i];
    return r;
  endfunction

  task automatic send_item(input logic [383:0] d);
    bit took;
    in_tdata <= d;
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk) took = in_tready;
      @(posedge clk);
    end while (!took);
    // idle each following cycle with the phase's probability
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic write_tolerance(input logic [31:0] v);
    bit took;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk) took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_directed();
    int q = 65536;
    int v[12];
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};                                send_item(seg_item(v));
    // both segments are points
    v = '{q, 2*q, 3*q, q, 2*q, 3*q, -q, 5, 7, -q, 5, 7};                     send_item(seg_item(v));
    // only A is a point
    v = '{q, q, 0, q, q, 0, 0, 0, 0, 4*q, 0, 0};                             send_item(seg_item(v));
    v = '{-9*q, q, 0, -9*q, q, 0, 0, 0, 0, 4*q, 0, 0};                       send_item(seg_item(v));
    // only B is a point
    v = '{0, 0, 0, 0, 8*q, 0, 3*q, 5*q, q, 3*q, 5*q, q};                     send_item(seg_item(v));
    v = '{0, 0, 0, 0, 8*q, 0, 3*q, 20*q, q, 3*q, 20*q, q};                   send_item(seg_item(v));
    // crossing, both params inside
    v = '{-q, 0, 0, q, 0, 0, 0, -q, q, 0, q, q};                             send_item(seg_item(v));
    // parallel, overlapping and disjoint
    v = '{0, 0, 0, 4*q, 0, 0, q, q, 0, 3*q, q, 0};                           send_item(seg_item(v));
    v = '{0, 0, 0, 4*q, 0, 0, 7*q, q, 0, 5*q, q, 0};                         send_item(seg_item(v));
    // skew, clamped so refinement runs
    v = '{0, 0, 0, q, 0, 0, 5*q, -q, q, 5*q, 2*q, 3*q};                      send_item(seg_item(v));
    v = '{0, 0, 0, q, q, 0, -6*q, 3*q, 2*q, -2*q, 9*q, -q};                  send_item(seg_item(v));
    // field extremes
    v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff,
          32'h80000000, -1};                                                 send_item(seg_item(v));
    v = '{32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000,
          -1, -1, -1, 1, 1, 1};                                              send_item(seg_item(v));
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};                    send_item(seg_item(v));
    // tiny segments near the tolerance
    v = '{0, 0, 0, 65, 0, 0, 0, 0, 0, 0, 66, 0};                             send_item(seg_item(v));
  endtask

  task automatic send_random(input int n);
    int v[12];
    int kind;
    int span;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(9);
      span = (kind < 5) ? (1 << $urandom_range(22, 8)) : 0;
      for (int i = 0; i < 12; i++) begin
        if (kind < 5) v[i] = $urandom_range(2 * span) - span;
        else v[i] = $urandom;
      end
      case (kind)
        5: for (int i = 0; i < 3; i++) v[3+i] = v[i] + $urandom_range(2) - 1;
        6: for (int i = 0; i < 3; i++) v[9+i] = v[6+i] + $urandom_range(2) - 1;
        7: for (int i = 0; i < 3; i++) begin
             v[i] = $urandom_range(1 << 20);
             v[3+i] = v[i] + 2 * (v[i] >>> 2);
             v[6+i] = v[i] + $urandom_range(1 << 18);
             v[9+i] = v[6+i] + (v[i] >>> 2);
           end
        default: ;
      endcase
      send_item(seg_item(v));
    end
  endtask

  initial begin
    logic [31:0] tols[5];
    tols = '{32'd4295, 32'd0, 32'hffffffff, 32'd0, 32'd4295};
    tols[3] = $urandom;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_tolerance(tols[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (ph == 0 || ph == 2) send_directed();
      if (ph == 0) begin
        send_random(10);
        hold_req = hold_req + 1;
      end
      send_random(80);
      drain();
    end
    if (fail_count == 0) begin
      $display("tb_segment_pair_closest_points OK");
    end else begin
      $display("tb_segment_pair_closest_points NOT OK");
    end
    $finish;
  end

endmodule
